// ----- rtl/nfcd_pkg.sv -----
// Shared types and constants for the NOR flash command device.
package nfcd_pkg;

   // Transaction kinds on the request channel
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAKER_ID      = 3'd0;
   localparam logic [2:0] CSR_PART_ID       = 3'd1;
   localparam logic [2:0] CSR_BOOT_AT_TOP   = 3'd2;
   localparam logic [2:0] CSR_SIZE_CODE     = 3'd3;
   localparam logic [2:0] CSR_PROGRAM_TICKS = 3'd4;
   localparam logic [2:0] CSR_ERASE_TICKS   = 3'd5;

   // Command bytes and unlock addresses
   localparam logic [7:0]  CMD_UNLOCK1 = 8'hAA;
   localparam logic [7:0]  CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0]  CMD_AUTOSEL = 8'h90;
   localparam logic [7:0]  CMD_PROGRAM = 8'hA0;
   localparam logic [7:0]  CMD_ERASE   = 8'h80;
   localparam logic [7:0]  CMD_SECTOR  = 8'h30;
   localparam logic [7:0]  CMD_RESET   = 8'hF0;
   localparam logic [10:0] ADDR_UNLOCK1 = 11'h555;
   localparam logic [10:0] ADDR_UNLOCK2 = 11'h2AA;

   localparam logic [15:0] ERASED_WORD = 16'hFFFF;

   // Device operating modes
   typedef enum logic [2:0] {
      MODE_READ  = 3'd0,
      MODE_ID    = 3'd1,
      MODE_PROG  = 3'd2,
      MODE_ERASE = 3'd3,
      MODE_FAIL  = 3'd4
   } mode_type;

   // Command sequence progress
   typedef enum logic [2:0] {
      STG_IDLE      = 3'd0,
      STG_UNLOCK1   = 3'd1,
      STG_UNLOCK2   = 3'd2,
      STG_PROG_DATA = 3'd3,
      STG_ERASE_SET = 3'd4,
      STG_ERASE_UL1 = 3'd5,
      STG_ERASE_UL2 = 3'd6
   } stage_type;

   typedef struct packed {
      logic accept;   // request beat taken, latch it and read the array
      logic exec;     // apply the latched beat, load the response
      logic clear;    // post-reset sweep step
      logic fill;     // erase sweep step
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic fill_last;
      logic fill_needed;
   } dp_status_type;

endpackage

// ----- rtl/nfcd_ctrl.sv -----
// Sequencer for the NOR flash command device: clear sweep, accept, execute, erase sweep.
module nfcd_ctrl import nfcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_FILL  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Take a beat only in idle and when the response slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept = req_valid && req_ready;
      cmd.exec   = (state_ff == ST_EXEC);
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.fill   = (state_ff == ST_FILL);
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (cmd.accept) state_in = ST_EXEC;
         ST_EXEC:  state_in = status.fill_needed ? ST_FILL : ST_IDLE;
         ST_FILL:  if (status.fill_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.exec) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat not executed next cycle");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside execute");

   a_no_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) || (state_ff == ST_FILL)) |-> !req_ready)
      else $error("request taken during array sweep");

endmodule

// ----- rtl/nfcd_datapath.sv -----
// Datapath of the NOR flash command device: array, command state, sector map, registers.
module nfcd_datapath import nfcd_pkg::*; #(
   parameter int WORD_ADDR_BITS = 20,
   parameter int MAX_SECTORS    = 35
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic [1:0]                req_op,
   input  logic [WORD_ADDR_BITS-1:0] req_word_addr,
   input  logic [15:0]               req_wdata,
   input  logic                      csr_valid,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output logic [15:0]               rsp_rdata,
   output logic                      rsp_is_busy,
   output logic [5:0]                rsp_sector_index
);

   localparam int AW = WORD_ADDR_BITS;
   localparam int SW = AW + 1;

   // Configuration registers
   logic [15:0] maker_id_ff, part_id_ff, prog_ticks_ff, erase_ticks_ff;
   logic        boot_top_ff;
   logic [1:0]  size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         maker_id_ff    <= 16'd1;
         part_id_ff     <= 16'd8938;
         boot_top_ff    <= 1'b0;
         size_ff        <= 2'd0;
         prog_ticks_ff  <= 16'd4;
         erase_ticks_ff <= 16'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAKER_ID:      maker_id_ff    <= csr_wdata;
            CSR_PART_ID:       part_id_ff     <= csr_wdata;
            CSR_BOOT_AT_TOP:   boot_top_ff    <= csr_wdata[0];
            CSR_SIZE_CODE:     size_ff        <= csr_wdata[1:0];
            CSR_PROGRAM_TICKS: prog_ticks_ff  <= csr_wdata;
            CSR_ERASE_TICKS:   erase_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective address width and array size
   logic [4:0]    ab;
   logic [AW-1:0] addr_mask;
   logic [SW-1:0] sw;

   always_comb begin
      ab = (size_ff > 2'd2) ? 5'd20 : 5'd18 + {3'd0, size_ff};
      if (32'(ab) > AW) ab = 5'(AW);
      addr_mask = ~({AW{1'b1}} << ab);
      sw = {{AW{1'b0}}, 1'b1} << ab;
   end

   // Latched beat and array read
   logic [1:0]    op_ff;
   logic [AW-1:0] a_ff;
   logic [15:0]   d_ff, mem_q_ff;
   logic [15:0]   mem_ff [2**AW];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         a_ff     <= req_word_addr & addr_mask;
         d_ff     <= req_wdata;
         mem_q_ff <= mem_ff[req_word_addr & addr_mask];
      end
   end

   // Sector lookup under the boot map
   logic [SW-1:0] a_ext, top, sb;
   logic [6:0]    idx;
   logic [AW-1:0] sec_base;
   logic [15:0]   sec_len;

   always_comb begin
      a_ext = {1'b0, a_ff};
      top   = sw - SW'(17'h4000);
      sb    = a_ext & ~SW'(17'h7FFF);
      if (boot_top_ff) begin
         if (a_ext < top) begin
            idx      = 7'(a_ext >> 15);
            sec_base = AW'(sb);
            sec_len  = ((top - sb) < SW'(17'h8000)) ? 16'(top - sb) : 16'h8000;
         end else if (a_ext < sw - SW'(17'h3000)) begin
            idx      = 7'(sw >> 15);
            sec_base = AW'(top);
            sec_len  = 16'h1000;
         end else if (a_ext < sw - SW'(17'h2000)) begin
            idx      = 7'(sw >> 15) + 7'd1;
            sec_base = AW'(sw - SW'(17'h3000));
            sec_len  = 16'h1000;
         end else begin
            idx      = 7'(sw >> 15) + 7'd2;
            sec_base = AW'(sw - SW'(17'h2000));
            sec_len  = 16'h2000;
         end
      end else begin
         if (a_ext < SW'(17'h2000)) begin
            idx = 7'd0; sec_base = '0; sec_len = 16'h2000;
         end else if (a_ext < SW'(17'h3000)) begin
            idx = 7'd1; sec_base = AW'(20'h2000); sec_len = 16'h1000;
         end else if (a_ext < SW'(17'h4000)) begin
            idx = 7'd2; sec_base = AW'(20'h3000); sec_len = 16'h1000;
         end else if (a_ext < SW'(17'h8000)) begin
            idx = 7'd3; sec_base = AW'(20'h4000); sec_len = 16'h4000;
         end else begin
            idx      = 7'd3 + 7'(a_ext >> 15);
            sec_base = AW'(sb);
            sec_len  = 16'h8000;
         end
      end
      if (idx > 7'(MAX_SECTORS - 1)) idx = 7'(MAX_SECTORS - 1);
   end

   // Device state
   mode_type      mode_ff, mode_in;
   stage_type     stage_ff, stage_in;
   logic [15:0]   busy_ff, busy_in;
   logic [1:0]    tog_ff, tog_in;
   logic          fail_ff, fail_in, poll_ff, poll_in;
   logic [AW-1:0] ebase_ff, ebase_in;
   logic [15:0]   elen_ff, elen_in, busy_dec;
   logic [15:0]   rdata_in;
   logic          prog_we, fill_needed;
   logic [7:0]    cmd_byte;
   logic [10:0]   lo;

   always_comb begin
      mode_in     = mode_ff;
      stage_in    = stage_ff;
      busy_in     = busy_ff;
      tog_in      = tog_ff;
      fail_in     = fail_ff;
      poll_in     = poll_ff;
      ebase_in    = ebase_ff;
      elen_in     = elen_ff;
      rdata_in    = 16'd0;
      prog_we     = 1'b0;
      fill_needed = 1'b0;
      cmd_byte    = d_ff[7:0];
      lo          = a_ff[10:0];
      busy_dec    = (busy_ff != 16'd0) ? busy_ff - 16'd1 : busy_ff;

      case (op_ff)
         OP_WRITE: begin
            if (mode_ff == MODE_PROG || mode_ff == MODE_ERASE) begin
               // ignore writes while busy
            end else if (mode_ff == MODE_FAIL) begin
               if (cmd_byte == CMD_RESET) begin
                  mode_in = MODE_READ; fail_in = 1'b0; stage_in = STG_IDLE;
               end
            end else if (stage_ff == STG_PROG_DATA) begin
               fail_in  = |(d_ff & ~mem_q_ff);
               prog_we  = 1'b1;
               poll_in  = ~d_ff[7];
               mode_in  = MODE_PROG;
               busy_in  = (prog_ticks_ff != 16'd0) ? prog_ticks_ff : 16'd1;
               stage_in = STG_IDLE;
            end else if (cmd_byte == CMD_RESET) begin
               mode_in = MODE_READ; stage_in = STG_IDLE;
            end else begin
               unique case (stage_ff) inside
                  STG_IDLE, STG_ERASE_SET: begin
                     if (lo == ADDR_UNLOCK1 && cmd_byte == CMD_UNLOCK1)
                        stage_in = (stage_ff == STG_IDLE) ? STG_UNLOCK1 : STG_ERASE_UL1;
                     else
                        stage_in = STG_IDLE;
                  end
                  STG_UNLOCK1, STG_ERASE_UL1: begin
                     if (lo == ADDR_UNLOCK2 && cmd_byte == CMD_UNLOCK2)
                        stage_in = (stage_ff == STG_UNLOCK1) ? STG_UNLOCK2 : STG_ERASE_UL2;
                     else
                        stage_in = STG_IDLE;
                  end
                  STG_UNLOCK2: begin
                     stage_in = STG_IDLE;
                     if (lo == ADDR_UNLOCK1) begin
                        if (cmd_byte == CMD_AUTOSEL)      mode_in  = MODE_ID;
                        else if (cmd_byte == CMD_PROGRAM) stage_in = STG_PROG_DATA;
                        else if (cmd_byte == CMD_ERASE)   stage_in = STG_ERASE_SET;
                     end
                  end
                  STG_ERASE_UL2: begin
                     stage_in = STG_IDLE;
                     if (cmd_byte == CMD_SECTOR) begin
                        ebase_in = sec_base;
                        elen_in  = sec_len;
                        poll_in  = 1'b0;
                        fail_in  = 1'b0;
                        mode_in  = MODE_ERASE;
                        busy_in  = (erase_ticks_ff != 16'd0) ? erase_ticks_ff : 16'd1;
                     end
                  end
                  default: stage_in = STG_IDLE;
               endcase
            end
         end
         OP_READ: begin
            if (mode_ff == MODE_PROG || mode_ff == MODE_ERASE || mode_ff == MODE_FAIL) begin
               rdata_in = {8'd0, poll_ff, tog_ff[0], fail_ff, 1'b0,
                           mode_ff == MODE_ERASE, tog_ff[1], 2'b00};
               tog_in[0] = ~tog_ff[0];
               if (mode_ff == MODE_ERASE) tog_in[1] = ~tog_ff[1];
            end else if (mode_ff == MODE_ID) begin
               rdata_in = (a_ff[1:0] == 2'd0) ? maker_id_ff :
                          (a_ff[1:0] == 2'd1) ? part_id_ff : 16'd0;
            end else begin
               rdata_in = mem_q_ff;
            end
         end
         OP_TICK: begin
            if (mode_ff == MODE_PROG || mode_ff == MODE_ERASE) begin
               busy_in = busy_dec;
               if (busy_dec == 16'd0) begin
                  if (mode_ff == MODE_ERASE) begin
                     fill_needed = 1'b1;
                     mode_in     = MODE_READ;
                  end else begin
                     mode_in = fail_ff ? MODE_FAIL : MODE_READ;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_READ;
         stage_ff <= STG_IDLE;
         busy_ff  <= 16'd0;
         tog_ff   <= 2'd0;
         fail_ff  <= 1'b0;
         poll_ff  <= 1'b0;
         ebase_ff <= '0;
         elen_ff  <= 16'd0;
      end else if (cmd.exec) begin
         mode_ff  <= mode_in;
         stage_ff <= stage_in;
         busy_ff  <= busy_in;
         tog_ff   <= tog_in;
         fail_ff  <= fail_in;
         poll_ff  <= poll_in;
         ebase_ff <= ebase_in;
         elen_ff  <= elen_in;
      end
   end

   // Load the response beat
   logic [15:0] rsp_rdata_ff;
   logic        rsp_is_busy_ff;
   logic [5:0]  rsp_sector_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_rdata_ff        <= rdata_in;
         rsp_is_busy_ff      <= (mode_in == MODE_PROG) || (mode_in == MODE_ERASE);
         rsp_sector_index_ff <= 6'(idx);
      end
   end

   assign rsp_rdata        = rsp_rdata_ff;
   assign rsp_is_busy      = rsp_is_busy_ff;
   assign rsp_sector_index = rsp_sector_index_ff;

   // Sweep counter for the post-reset clear and the erase fill
   logic [AW-1:0] sweep_ff, sweep_in;

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.exec) sweep_in = '0;
      else if (cmd.clear || cmd.fill) sweep_in = sweep_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else       sweep_ff <= sweep_in;
   end

   always_comb begin
      status.clear_last  = (sweep_ff == {AW{1'b1}});
      status.fill_last   = (sweep_ff == AW'(elen_ff - 16'd1));
      status.fill_needed = cmd.exec && fill_needed;
   end

   // Array write port
   logic          we;
   logic [AW-1:0] waddr;
   logic [15:0]   wdata;

   always_comb begin
      we    = 1'b0;
      waddr = a_ff;
      wdata = mem_q_ff & d_ff;
      if (cmd.clear) begin
         we = 1'b1; waddr = sweep_ff; wdata = ERASED_WORD;
      end else if (cmd.fill) begin
         we = 1'b1; waddr = ebase_ff + sweep_ff; wdata = ERASED_WORD;
      end else if (cmd.exec && prog_we) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

endmodule

// ----- rtl/nor_flash_command_device.sv -----
// Top level of the NOR flash command device.
// An accepted request beat is latched, applied in the execute state, and its response is registered there.
// A new request is taken only after the last one has left the execute state, while responses are taken promptly.
// A tick that ends a sector erase starts the erase sweep, which writes each sector word (4096 to 32768)
// of the array in turn; no request is taken meanwhile.
// Reset: synchronous; a clear pass over all 2**WORD_ADDR_BITS words erases the array first.
module nor_flash_command_device import nfcd_pkg::*; #(
   parameter int WORD_ADDR_BITS = 20,
   parameter int MAX_SECTORS    = 35
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  logic [WORD_ADDR_BITS-1:0] req_word_addr,
   input  logic [15:0]               req_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_rdata,
   output logic                      rsp_is_busy,
   output logic [5:0]                rsp_sector_index,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   nfcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nfcd_datapath #(
      .WORD_ADDR_BITS (WORD_ADDR_BITS),
      .MAX_SECTORS    (MAX_SECTORS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_word_addr    (req_word_addr),
      .req_wdata        (req_wdata),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_rdata        (rsp_rdata),
      .rsp_is_busy      (rsp_is_busy),
      .rsp_sector_index (rsp_sector_index)
   );

endmodule

// ----- sim/nor_flash_command_device_test.sv -----
// Self-checking testbench for the NOR flash command device.
`timescale 1ns / 100ps

module nor_flash_command_device_test import nfcd_pkg::*;;

   // Opcode outside the defined set
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [19:0] addr;
      logic [15:0] data;
   } bus_beat_type;

   typedef struct {
      logic [15:0] rdata;
      logic        busy;
      logic [5:0]  sector;
   } flash_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_READ;
   logic [19:0] req_word_addr = '0;
   logic [15:0] req_wdata = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_rdata;
   logic        rsp_is_busy;
   logic [5:0]  rsp_sector_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   nor_flash_command_device dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Flash behavior mirror
   bit [15:0]   flash_cells [0:(1 << 20) - 1];
   stage_type   seq_stage;
   mode_type    chip_mode;
   int unsigned busy_count;
   logic [1:0]  toggle_state;
   logic        prog_fail;
   logic        poll_dq7;
   logic [19:0] erase_start;
   int unsigned erase_words;
   logic [15:0] cfg_maker, cfg_part, cfg_prog_ticks, cfg_erase_ticks;
   logic        cfg_top;
   logic [1:0]  cfg_size;

   bus_beat_type     beats_to_send[$];
   flash_result_type expected_results[$];
   int               errors = 0;
   int               in_flight = 0;
   bit               quiet = 1'b0;
   bit               req_taken = 1'b0;
   bit               csr_taken = 1'b0;
   int               req_gap = 0;
   int               rsp_stall = 0;
   logic [19:0]      hot_addrs [8];

   function automatic int unsigned size_bits();
      return 18 + ((cfg_size > 2) ? 2 : cfg_size);
   endfunction

   task automatic locate_sector(input logic [19:0] a, output logic [5:0] idx,
                                output logic [19:0] base, output int unsigned len);
      int unsigned sw, top, n;
      sw = 1 << size_bits();
      top = sw - 32'h4000;
      if (cfg_top) begin
         if (a < top) begin
            n = {12'd0, a} >> 15;
            base = a & ~20'h7FFF;
            len = (top - base < 32'h8000) ? top - base : 32'h8000;
         end else if (a < sw - 32'h3000) begin
            n = sw >> 15; base = 20'(top); len = 32'h1000;
         end else if (a < sw - 32'h2000) begin
            n = (sw >> 15) + 1; base = 20'(sw - 32'h3000); len = 32'h1000;
         end else begin
            n = (sw >> 15) + 2; base = 20'(sw - 32'h2000); len = 32'h2000;
         end
      end else begin
         if (a < 20'h2000) begin n = 0; base = '0; len = 32'h2000; end
         else if (a < 20'h3000) begin n = 1; base = 20'h2000; len = 32'h1000; end
         else if (a < 20'h4000) begin n = 2; base = 20'h3000; len = 32'h1000; end
         else if (a < 20'h8000) begin n = 3; base = 20'h4000; len = 32'h4000; end
         else begin n = 3 + ({12'd0, a} >> 15); base = a & ~20'h7FFF; len = 32'h8000; end
      end
      // clamp to the last sector
      if (n > 34) n = 34;
      idx = n[5:0];
   endtask

   task automatic apply_bus_write(input logic [19:0] a, input logic [15:0] d);
      logic [7:0]  cmd;
      logic [5:0]  idx;
      logic [19:0] base;
      int unsigned len;
      cmd = d[7:0];
      if (chip_mode == MODE_PROG || chip_mode == MODE_ERASE) return;
      if (chip_mode == MODE_FAIL) begin
         if (cmd == CMD_RESET) begin
            chip_mode = MODE_READ; prog_fail = 1'b0; seq_stage = STG_IDLE;
         end
         return;
      end
      // program data beat: AND into the cell
      if (seq_stage == STG_PROG_DATA) begin
         prog_fail = (d & ~flash_cells[a]) != 0;
         flash_cells[a] = flash_cells[a] & d;
         poll_dq7 = ~d[7];
         chip_mode = MODE_PROG;
         busy_count = (cfg_prog_ticks != 0) ? cfg_prog_ticks : 1;
         seq_stage = STG_IDLE;
         return;
      end
      if (cmd == CMD_RESET) begin
         chip_mode = MODE_READ; seq_stage = STG_IDLE;
         return;
      end
      case (seq_stage) inside
         STG_IDLE, STG_ERASE_SET: begin
            if (a[10:0] == ADDR_UNLOCK1 && cmd == CMD_UNLOCK1)
               seq_stage = (seq_stage == STG_IDLE) ? STG_UNLOCK1 : STG_ERASE_UL1;
            else
               seq_stage = STG_IDLE;
         end
         STG_UNLOCK1, STG_ERASE_UL1: begin
            if (a[10:0] == ADDR_UNLOCK2 && cmd == CMD_UNLOCK2)
               seq_stage = (seq_stage == STG_UNLOCK1) ? STG_UNLOCK2 : STG_ERASE_UL2;
            else
               seq_stage = STG_IDLE;
         end
         STG_UNLOCK2: begin
            seq_stage = STG_IDLE;
            if (a[10:0] == ADDR_UNLOCK1) begin
               if (cmd == CMD_AUTOSEL) chip_mode = MODE_ID;
               else if (cmd == CMD_PROGRAM) seq_stage = STG_PROG_DATA;
               else if (cmd == CMD_ERASE) seq_stage = STG_ERASE_SET;
            end
         end
         STG_ERASE_UL2: begin
            seq_stage = STG_IDLE;
            if (cmd == CMD_SECTOR) begin
               locate_sector(a, idx, base, len);
               erase_start = base; erase_words = len;
               poll_dq7 = 1'b0; prog_fail = 1'b0;
               chip_mode = MODE_ERASE;
               busy_count = (cfg_erase_ticks != 0) ? cfg_erase_ticks : 1;
            end
         end
         default: seq_stage = STG_IDLE;
      endcase
   endtask

   task automatic apply_tick();
      if (chip_mode != MODE_PROG && chip_mode != MODE_ERASE) return;
      if (busy_count > 0) busy_count--;
      if (busy_count != 0) return;
      if (chip_mode == MODE_ERASE) begin
         for (int unsigned i = 0; i < erase_words; i++)
            flash_cells[(erase_start + i) & 20'hFFFFF] = ERASED_WORD;
         chip_mode = MODE_READ;
      end else begin
         chip_mode = prog_fail ? MODE_FAIL : MODE_READ;
      end
   endtask

   task automatic predict_flash(input bus_beat_type b, output flash_result_type r);
      logic [19:0] a, base;
      int unsigned len;
      logic        erasing;
      a = b.addr & 20'((32'd1 << size_bits()) - 32'd1);
      r.rdata = '0;
      locate_sector(a, r.sector, base, len);
      case (b.op)
         OP_WRITE: apply_bus_write(a, b.data);
         OP_READ: begin
            if (chip_mode == MODE_PROG || chip_mode == MODE_ERASE ||
                chip_mode == MODE_FAIL) begin
               // status word, then flip the toggle bits
               erasing = chip_mode == MODE_ERASE;
               r.rdata = {8'h00, poll_dq7, toggle_state[0], prog_fail, 1'b0,
                          erasing, toggle_state[1], 2'b00};
               toggle_state[0] = ~toggle_state[0];
               if (erasing) toggle_state[1] = ~toggle_state[1];
            end else if (chip_mode == MODE_ID) begin
               r.rdata = (a[1:0] == 2'd0) ? cfg_maker : (a[1:0] == 2'd1) ? cfg_part : 16'h0;
            end else begin
               r.rdata = flash_cells[a];
            end
         end
         OP_TICK: apply_tick();
         default: ;
      endcase
      r.busy = chip_mode == MODE_PROG || chip_mode == MODE_ERASE;
   endtask

   // Monitor: take beats at the rising edge, predict and check
   always @(posedge clock) begin
      flash_result_type exp_r, got;
      bus_beat_type     b;
      if (!reset) begin
         if (req_valid && req_ready) begin
            b.op = req_op; b.addr = req_word_addr; b.data = req_wdata;
            predict_flash(b, exp_r);
            expected_results.push_back(exp_r);
            req_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAKER_ID:      cfg_maker = csr_wdata;
               CSR_PART_ID:       cfg_part = csr_wdata;
               CSR_BOOT_AT_TOP:   cfg_top = csr_wdata[0];
               CSR_SIZE_CODE:     cfg_size = csr_wdata[1:0];
               CSR_PROGRAM_TICKS: cfg_prog_ticks = csr_wdata;
               CSR_ERASE_TICKS:   cfg_erase_ticks = csr_wdata;
               default: ;
            endcase
            csr_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got.rdata = rsp_rdata; got.busy = rsp_is_busy; got.sector = rsp_sector_index;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response rdata %h busy %b sector %0d",
                        $time, got.rdata, got.busy, got.sector);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               in_flight--;
               if (got.rdata !== exp_r.rdata) begin
                  $display("%0t: rdata expected %h actual %h", $time, exp_r.rdata, got.rdata);
                  errors++;
               end
               if (got.busy !== exp_r.busy) begin
                  $display("%0t: is_busy expected %b actual %b", $time, exp_r.busy, got.busy);
                  errors++;
               end
               if (got.sector !== exp_r.sector) begin
                  $display("%0t: sector_index expected %0d actual %0d",
                           $time, exp_r.sector, got.sector);
                  errors++;
               end
            end
         end
      end
   end

   // Driver: advance the request channel and stall the response channel
   always @(negedge clock) begin
      bus_beat_type b;
      logic         next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (beats_to_send.size() != 0) begin
            b = beats_to_send.pop_front();
            in_flight++;
            req_op <= b.op; req_word_addr <= b.addr; req_wdata <= b.data;
            next_valid = 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) req_gap = $urandom_range(1, 9);
         end
      end
      req_valid <= next_valid;
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(input logic [1:0] op, input logic [19:0] a, input logic [15:0] d);
      bus_beat_type b;
      b.op = op; b.addr = a; b.data = d;
      beats_to_send.push_back(b);
   endtask

   task automatic send_unlock();
      send(OP_WRITE, {9'($urandom), ADDR_UNLOCK1}, {8'($urandom), CMD_UNLOCK1});
      send(OP_WRITE, {9'($urandom), ADDR_UNLOCK2}, {8'($urandom), CMD_UNLOCK2});
   endtask

   task automatic send_command(input logic [7:0] cmd);
      send_unlock();
      send(OP_WRITE, {9'($urandom), ADDR_UNLOCK1}, {8'($urandom), cmd});
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      do @(negedge clock); while (!csr_taken);
      csr_taken = 1'b0;
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued beat has been answered
   task automatic settle();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || in_flight != 0);
      repeat (6) @(negedge clock);
   endtask

   // Bring the chip back to read mode with no sequence open
   task automatic drain_device();
      settle();
      while (chip_mode != MODE_READ || seq_stage != STG_IDLE) begin
         if (chip_mode == MODE_PROG || chip_mode == MODE_ERASE)
            repeat (busy_count) send(OP_TICK, '0, '0);
         else
            send(OP_WRITE, '0, {8'h00, CMD_RESET});
         settle();
      end
   endtask

   function automatic logic [19:0] pick_addr();
      if ($urandom_range(0, 1)) return hot_addrs[$urandom_range(0, 7)];
      return 20'($urandom);
   endfunction

   // Erase target, mostly inside the small boot sectors
   function automatic logic [19:0] pick_erase_addr();
      int unsigned sw;
      sw = 1 << size_bits();
      if ($urandom_range(0, 9) == 0) return 20'($urandom);
      if (cfg_top) return 20'(sw - 32'h4000 + $urandom_range(0, 32'h3FFF));
      return 20'($urandom_range(0, 32'h3FFF));
   endfunction

   task automatic send_busy_wait(input int unsigned ticks, input logic [19:0] a);
      for (int unsigned i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 2) == 0) send(OP_READ, a, 16'($urandom));
         send(OP_TICK, 20'($urandom), 16'($urandom));
      end
      send(OP_READ, a, 16'($urandom));
   endtask

   task automatic random_phase(input int items);
      logic [19:0] a;
      int          r;
      int unsigned ticks;
      for (int i = 0; i < 8; i++) hot_addrs[i] = 20'($urandom);
      while (items > 0) begin
         r = $urandom_range(0, 99);
         a = pick_addr();
         ticks = (cfg_prog_ticks != 0) ? cfg_prog_ticks : 1;
         if (r < 35) begin
            send_command(CMD_PROGRAM);
            send(OP_WRITE, a, $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
            send_busy_wait(ticks + $urandom_range(0, 2), a);
            if ($urandom_range(0, 1)) send(OP_WRITE, 20'($urandom), {8'($urandom), CMD_RESET});
            items -= 7 + ticks;
         end else if (r < 39) begin
            a = pick_erase_addr();
            ticks = (cfg_erase_ticks != 0) ? cfg_erase_ticks : 1;
            send_command(CMD_ERASE);
            send_unlock();
            send(OP_WRITE, a, {8'($urandom), CMD_SECTOR});
            send_busy_wait(ticks + 1, a);
            items -= 10 + ticks;
         end else if (r < 48) begin
            send_command(CMD_AUTOSEL);
            repeat (3) send(OP_READ, 20'($urandom), 16'($urandom));
            send(OP_WRITE, 20'($urandom), {8'($urandom), CMD_RESET});
            items -= 7;
         end else if (r < 58) begin
            // break the sequence at a random point
            send(OP_WRITE, {9'($urandom), ADDR_UNLOCK1}, {8'($urandom), CMD_UNLOCK1});
            if ($urandom_range(0, 1))
               send(OP_WRITE, {9'($urandom), ADDR_UNLOCK2}, {8'($urandom), CMD_UNLOCK2});
            send(OP_WRITE, 20'($urandom),
                 $urandom_range(0, 1) ? {8'($urandom), CMD_RESET} : 16'($urandom));
            send(OP_READ, a, 16'($urandom));
            items -= 4;
         end else if (r < 85) begin
            send(OP_READ, a, 16'($urandom));
            items--;
         end else begin
            send(2'($urandom), 20'($urandom), 16'($urandom));
            items--;
         end
      end
      drain_device();
   endtask

   initial begin
      for (int i = 0; i < (1 << 20); i++) flash_cells[i] = ERASED_WORD;
      seq_stage = STG_IDLE; chip_mode = MODE_READ; busy_count = 0;
      toggle_state = '0; prog_fail = 1'b0; poll_dq7 = 1'b0;
      erase_start = '0; erase_words = 0;
      cfg_maker = 16'd1; cfg_part = 16'd8938; cfg_top = 1'b0; cfg_size = 2'd0;
      cfg_prog_ticks = 16'd4; cfg_erase_ticks = 16'd64;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: erased reads, IDs, program with a 0 to 1 failure, commands
      send(OP_READ, 20'h00000, 16'h0000);
      send(OP_READ, 20'hFFFFF, 16'hFFFF);
      send(OP_TICK, 20'h12345, 16'h0000);
      send(OP_UNUSED, 20'h54321, 16'hFFFF);
      send_command(CMD_AUTOSEL);
      send(OP_READ, 20'h00000, '0);
      send(OP_READ, 20'h00001, '0);
      send(OP_READ, 20'h00002, '0);
      send(OP_WRITE, 20'h00000, {8'hFF, CMD_RESET});
      send_command(CMD_PROGRAM);
      send(OP_WRITE, 20'h08000, 16'h0F00);
      send(OP_WRITE, 20'h08000, 16'h0000);
      send(OP_READ, 20'h08000, '0);
      repeat (4) send(OP_TICK, '0, '0);
      send(OP_READ, 20'h08000, '0);
      send_command(CMD_PROGRAM);
      send(OP_WRITE, 20'h08000, 16'hFF80);
      repeat (4) send(OP_TICK, '0, '0);
      send(OP_READ, 20'h08000, '0);
      send(OP_WRITE, 20'h08000, 16'h0000);
      send(OP_WRITE, 20'h08000, {8'h00, CMD_RESET});
      send(OP_READ, 20'h08000, '0);
      drain_device();

      // Top boot, largest size, shortest program time, short erase time, small boot sector erase
      write_reg(CSR_MAKER_ID, 16'h0000);
      write_reg(CSR_PART_ID, 16'hFFFF);
      write_reg(CSR_BOOT_AT_TOP, 16'd1);
      write_reg(CSR_SIZE_CODE, 16'd2);
      write_reg(CSR_PROGRAM_TICKS, 16'd1);
      write_reg(CSR_ERASE_TICKS, 16'd2);
      send_command(CMD_PROGRAM);
      send(OP_WRITE, 20'hFF000, 16'h1234);
      send(OP_TICK, '0, '0);
      send_command(CMD_ERASE);
      send_unlock();
      send(OP_WRITE, 20'hFF000, {8'h00, CMD_SECTOR});
      send_busy_wait(3, 20'hFF000);
      random_phase(180);

      // Bottom boot, 1MB, zero tick counts
      write_reg(CSR_MAKER_ID, 16'hFFFF);
      write_reg(CSR_PART_ID, 16'h0000);
      write_reg(CSR_BOOT_AT_TOP, 16'd0);
      write_reg(CSR_SIZE_CODE, 16'd1);
      write_reg(CSR_PROGRAM_TICKS, 16'd0);
      write_reg(CSR_ERASE_TICKS, 16'd0);
      random_phase(180);

      // Longest busy times: no operation is started here
      write_reg(CSR_SIZE_CODE, 16'd3);
      write_reg(CSR_PROGRAM_TICKS, 16'hFFFF);
      write_reg(CSR_ERASE_TICKS, 16'hFFFF);
      for (int i = 0; i < 30; i++) send(OP_READ, 20'($urandom), 16'($urandom));
      send_command(CMD_AUTOSEL);
      repeat (4) send(OP_READ, 20'($urandom), '0);
      send(OP_WRITE, '0, {8'h00, CMD_RESET});
      drain_device();

      // Random settings
      write_reg(CSR_MAKER_ID, 16'($urandom));
      write_reg(CSR_PART_ID, 16'($urandom));
      write_reg(CSR_BOOT_AT_TOP, 16'($urandom_range(0, 1)));
      write_reg(CSR_SIZE_CODE, 16'd0);
      write_reg(CSR_PROGRAM_TICKS, 16'($urandom_range(1, 6)));
      write_reg(CSR_ERASE_TICKS, 16'($urandom_range(1, 20)));
      random_phase(250);

      // Last stretch with both sides always ready
      write_reg(CSR_BOOT_AT_TOP, 16'($urandom_range(0, 1)));
      write_reg(CSR_SIZE_CODE, 16'($urandom_range(0, 2)));
      quiet = 1'b1;
      random_phase(220);

      repeat (20) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("nor_flash_command_device_test passed");
      else
         $display("nor_flash_command_device_test failed");
      $finish;
   end

   // Hold off a hung run
   initial begin
      #200_000_000;
      $display("nor_flash_command_device_test failed");
      $finish;
   end

endmodule
